// ===== rtl/plotter_line_step_generator_assert.svh =====
// Assertion macros for the plotter line step generator checker.
// Needs nothing else; include by bare file name.
`ifndef PLOTTER_LINE_STEP_GENERATOR_ASSERT_SVH
`define PLOTTER_LINE_STEP_GENERATOR_ASSERT_SVH

// same-cycle implication, reset masks the check
`define PLG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("plg assertion failed");

// next-cycle implication
`define PLG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("plg assertion failed");

`endif

// ===== rtl/plg_pkg.sv =====
// Shared types and constants of the plotter line step generator.
// No dependencies.
package plg_pkg;

	localparam int CFG_W      = 15;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = CFG_IDX_W'(1);

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_MOVE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_BUSY  = 2'd2
	} plg_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} plg_state_t;

endpackage

// ===== rtl/plg_ifs.sv =====
// Channel interfaces of the plotter line step generator: command, result, config.
// Depends on plg_pkg for the config port widths.
interface plg_cmd_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic signed [COORD_WIDTH-1:0] target_x;
	logic signed [COORD_WIDTH-1:0] target_y;
	logic                          pen_request;

	modport source (output valid, req_type, target_x, target_y, pen_request, input ready);
	modport sink   (input valid, req_type, target_x, target_y, pen_request, output ready);
endinterface

interface plg_res_if #(
	parameter int COORD_WIDTH       = 16,
	parameter int MOTOR_COUNT_WIDTH = 32
);
	logic                                valid;
	logic                                ready;
	logic [1:0]                          status;
	logic                                step_pulse;
	logic                                motor_a_dir;
	logic                                motor_b_dir;
	logic                                pen_level;
	logic                                busy_res;
	logic signed [COORD_WIDTH-1:0]       pos_x;
	logic signed [COORD_WIDTH-1:0]       pos_y;
	logic signed [MOTOR_COUNT_WIDTH-1:0] motor_a_count;
	logic signed [MOTOR_COUNT_WIDTH-1:0] motor_b_count;

	modport source (output valid, status, step_pulse, motor_a_dir, motor_b_dir, pen_level,
		busy_res, pos_x, pos_y, motor_a_count, motor_b_count, input ready);
	modport sink   (input valid, status, step_pulse, motor_a_dir, motor_b_dir, pen_level,
		busy_res, pos_x, pos_y, motor_a_count, motor_b_count, output ready);
endinterface

interface plg_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [plg_pkg::CFG_IDX_W-1:0]    index;
	logic [plg_pkg::CFG_DATA_W-1:0]   value;

	modport source (output valid, index, value, input ready);
	modport sink   (input valid, index, value, output ready);
endinterface

// ===== rtl/plotter_line_step_generator.sv =====
// Plotter line step generator: CoreXY line walker with a serial divider.
// Depends on plg_pkg and the channel interfaces in plg_ifs.sv.
//
// Usage:
//   cmd carries one item per beat: a move command (req_type 1) or a tick (req_type 0).
//   A command loads a line unless zero-length; rejected if busy or above max_x/max_y.
//   Each tick advances the line by at most one unit move; a step pulses both motors.
//   res carries exactly one result beat per cmd beat, in order.
//   cfg writes max_x (index 0) or max_y (index 1); always ready, other indexes dropped.
// Result timing:
//   Commands, idle ticks and vertical moves: result registered at the accepting edge;
//   the next item can be taken once res takes this result.
//   Horizontal moves: result waits for the restoring divider that recomputes the
//   y goal trunc(dy*i/|dx|), one quotient bit per cycle.
// Reset: position, motor counts, pen and line state clear to zero, limits to 32767.
// Stall: the result register holds its beat until res.ready; cmd.ready stays low
//   while the divider runs or while an untaken result would be overwritten.
module plotter_line_step_generator #(
	parameter int COORD_WIDTH       = 16,
	parameter int MOTOR_COUNT_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	plg_cmd_if.sink   cmd,
	plg_res_if.source res,
	plg_cfg_if.sink   cfg
);
	import plg_pkg::*;

	localparam int W      = COORD_WIDTH;
	localparam int MW     = MOTOR_COUNT_WIDTH;
	localparam int CNT_W  = $clog2(W);
	localparam int CMP_W  = ((W > CFG_W) ? W : CFG_W) + 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

	plg_state_t state_q, state_d;

	logic signed [W-1:0] cur_x_q, cur_y_q, start_y_q, goal_y_q;
	logic [W-1:0]        adx_q, ady_q, x_index_q;
	logic                dx_neg_q, dy_neg_q;
	logic [2*W-1:0]      prod_q, div_rem_q;
	logic [CNT_W-1:0]    div_cnt_q;
	logic                moving_q, pen_q;
	logic [MW-1:0]       mot_a_q, mot_b_q;
	logic [CFG_W-1:0]    max_x_q, max_y_q;
	logic                res_valid_q;

	plg_status_t         res_status_q;
	logic                res_pulse_q, res_a_q, res_b_q, res_pen_q, res_busy_q;
	logic signed [W-1:0] res_x_q, res_y_q;
	logic [MW-1:0]       res_ma_q, res_mb_q;

	logic accept, is_move, is_tick, div_run, fin, in_ready, res_load;

	// command decode
	logic signed [CMP_W-1:0] tx_ext, ty_ext;
	logic                    over, zero_len, line_go;
	logic signed [W:0]       dx_full, dy_full;
	logic [W-1:0]            adx_nxt, ady_nxt;

	// tick decode
	logic                y_step, y_up, x_step, any_step, x_end, a_ccw, b_ccw;
	logic signed [W-1:0] cur_y_nxt, cur_x_nxt;
	logic [MW-1:0]       mot_a_nxt, mot_b_nxt;
	logic [2*W-1:0]      prod_nxt;

	// divider step and finish
	logic [W:0]          div_t, div_r;
	logic                div_ge;
	logic [W-1:0]        quo, quo_off;
	logic signed [W-1:0] goal_new;
	logic                moving_fin;

	// result payload for the accepting edge
	plg_status_t         o_status;
	logic                o_pulse, o_a, o_b, o_pen, o_busy;
	logic signed [W-1:0] o_x, o_y;
	logic [MW-1:0]       o_ma, o_mb;

	assign accept  = cmd.valid && in_ready;
	assign is_move = (cmd.req_type == REQ_MOVE);
	assign is_tick = (cmd.req_type == REQ_TICK);
	// every beat but a horizontal move answers at once; that one answers from the finish
	assign res_load = fin || (accept && !(is_tick && x_step));

	always_comb begin
		tx_ext   = CMP_W'(cmd.target_x);
		ty_ext   = CMP_W'(cmd.target_y);
		over     = (tx_ext > $signed({{(CMP_W-CFG_W){1'b0}}, max_x_q}))
			|| (ty_ext > $signed({{(CMP_W-CFG_W){1'b0}}, max_y_q}));
		zero_len = (cmd.target_x == cur_x_q) && (cmd.target_y == cur_y_q);
		line_go  = !moving_q && !over && !zero_len;
		dx_full  = (W+1)'(cmd.target_x) - (W+1)'(cur_x_q);
		dy_full  = (W+1)'(cmd.target_y) - (W+1)'(cur_y_q);
		adx_nxt  = dx_full[W] ? W'(-dx_full) : W'(dx_full);
		ady_nxt  = dy_full[W] ? W'(-dy_full) : W'(dy_full);
	end

	always_comb begin
		y_step    = moving_q && (cur_y_q != goal_y_q);
		y_up      = (goal_y_q > cur_y_q);
		x_end     = (x_index_q == adx_q);
		x_step    = moving_q && !y_step && !x_end;
		any_step  = y_step || x_step;
		a_ccw     = y_step ? y_up : !dx_neg_q;
		b_ccw     = y_step ? !y_up : !dx_neg_q;
		cur_y_nxt = y_up ? cur_y_q + W'(1) : cur_y_q - W'(1);
		cur_x_nxt = dx_neg_q ? cur_x_q - W'(1) : cur_x_q + W'(1);
		mot_a_nxt = a_ccw ? mot_a_q + MW'(1) : mot_a_q - MW'(1);
		mot_b_nxt = b_ccw ? mot_b_q + MW'(1) : mot_b_q - MW'(1);
		prod_nxt  = prod_q + (2*W)'(ady_q);
	end

	// restoring divide: one quotient bit per cycle, quotient lands in the low half
	always_comb begin
		div_t      = {div_rem_q[2*W-1:W], div_rem_q[W-1]};
		div_ge     = (div_t >= {1'b0, adx_q});
		div_r      = div_ge ? div_t - {1'b0, adx_q} : div_t;
		quo        = div_rem_q[W-1:0];
		quo_off    = dy_neg_q ? W'(0) - quo : quo;
		goal_new   = start_y_q + $signed(quo_off);
		moving_fin = !(x_end && (cur_y_q == goal_new));
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_tick && x_step) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_cnt_q == CNT_LAST) state_d = ST_FIN;
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE) && (!res_valid_q || res.ready);
		div_run  = (state_q == ST_DIV);
		fin      = (state_q == ST_FIN);
	end

	always_comb begin
		o_status = STATUS_OK;
		o_pulse  = 1'b0;
		o_a      = 1'b0;
		o_b      = 1'b0;
		o_pen    = pen_q;
		o_busy   = moving_q;
		o_x      = cur_x_q;
		o_y      = cur_y_q;
		o_ma     = mot_a_q;
		o_mb     = mot_b_q;
		if (is_move) begin
			if (moving_q) begin
				o_status = STATUS_BUSY;
			end else begin
				o_status = over ? STATUS_RANGE : STATUS_OK;
				o_pen    = cmd.pen_request;
				o_busy   = line_go;
			end
		end else if (any_step) begin
			o_pulse = 1'b1;
			o_a     = a_ccw;
			o_b     = b_ccw;
			o_ma    = mot_a_nxt;
			o_mb    = mot_b_nxt;
			if (y_step) begin
				o_y    = cur_y_nxt;
				o_busy = !(x_end && (cur_y_nxt == goal_y_q));
			end else begin
				o_x    = cur_x_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			start_y_q   <= '0;
			goal_y_q    <= '0;
			adx_q       <= '0;
			ady_q       <= '0;
			x_index_q   <= '0;
			dx_neg_q    <= 1'b0;
			dy_neg_q    <= 1'b0;
			prod_q      <= '0;
			div_rem_q   <= '0;
			div_cnt_q   <= '0;
			moving_q    <= 1'b0;
			pen_q       <= 1'b0;
			mot_a_q     <= '0;
			mot_b_q     <= '0;
			max_x_q     <= '1;
			max_y_q     <= '1;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_MAX_X: max_x_q <= cfg.value[CFG_W-1:0];
					CFG_MAX_Y: max_y_q <= cfg.value[CFG_W-1:0];
					default: ;
				endcase
			end

			if (res_load) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;

			if (accept) begin
				if (is_move) begin
					if (!moving_q) pen_q <= cmd.pen_request;
					if (line_go) begin
						start_y_q <= cur_y_q;
						goal_y_q  <= (dx_full == '0) ? cmd.target_y : cur_y_q;
						adx_q     <= adx_nxt;
						ady_q     <= ady_nxt;
						dx_neg_q  <= dx_full[W];
						dy_neg_q  <= dy_full[W];
						x_index_q <= '0;
						prod_q    <= '0;
						moving_q  <= 1'b1;
					end
				end else if (y_step) begin
					cur_y_q     <= cur_y_nxt;
					mot_a_q     <= mot_a_nxt;
					mot_b_q     <= mot_b_nxt;
					moving_q    <= !(x_end && (cur_y_nxt == goal_y_q));
				end else if (x_step) begin
					// result waits for the new goal from the divider
					cur_x_q   <= cur_x_nxt;
					x_index_q <= x_index_q + W'(1);
					mot_a_q   <= mot_a_nxt;
					mot_b_q   <= mot_b_nxt;
					prod_q    <= prod_nxt;
					div_rem_q <= prod_nxt;
					div_cnt_q <= '0;
				end
			end

			if (div_run) begin
				div_rem_q <= {div_r[W-1:0], div_rem_q[W-2:0], div_ge};
				div_cnt_q <= div_cnt_q + CNT_W'(1);
			end

			if (fin) begin
				goal_y_q    <= goal_new;
				moving_q    <= moving_fin;
			end
		end
	end

	// result payload; busy is patched when a horizontal move finishes
	always_ff @(posedge clk) begin
		if (accept) begin
			res_status_q <= o_status;
			res_pulse_q  <= o_pulse;
			res_a_q      <= o_a;
			res_b_q      <= o_b;
			res_pen_q    <= o_pen;
			res_busy_q   <= o_busy;
			res_x_q      <= o_x;
			res_y_q      <= o_y;
			res_ma_q     <= o_ma;
			res_mb_q     <= o_mb;
		end else if (fin) begin
			res_busy_q   <= moving_fin;
		end
	end

	assign cmd.ready         = in_ready;
	assign cfg.ready         = 1'b1;
	assign res.valid         = res_valid_q;
	assign res.status        = res_status_q;
	assign res.step_pulse    = res_pulse_q;
	assign res.motor_a_dir   = res_a_q;
	assign res.motor_b_dir   = res_b_q;
	assign res.pen_level     = res_pen_q;
	assign res.busy_res      = res_busy_q;
	assign res.pos_x         = res_x_q;
	assign res.pos_y         = res_y_q;
	assign res.motor_a_count = $signed(res_ma_q);
	assign res.motor_b_count = $signed(res_mb_q);

endmodule

// ===== rtl/plg_checker.sv =====
// Port-level checks for plotter_line_step_generator, bound to the top level.
// Depends on plg_pkg and plotter_line_step_generator_assert.svh.
`include "plotter_line_step_generator_assert.svh"

module plg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] res_status,
	input logic       res_step_pulse,
	input logic       res_motor_a_dir,
	input logic       res_motor_b_dir
);
	import plg_pkg::*;

	// a held result beat stays offered
	`PLG_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	// a new command never lands on top of an untaken result
	`PLG_ASSERT_IMP(a_no_overrun, clk, arst_n, cmd_ready, !res_valid || res_ready)
	// directions read zero without a pulse
	`PLG_ASSERT_IMP(a_dir_idle, clk, arst_n, res_valid && !res_step_pulse,
		!res_motor_a_dir && !res_motor_b_dir)
	// only ticks pulse, so a pulsing beat must report ok
	`PLG_ASSERT_IMP(a_pulse_ok, clk, arst_n, res_valid && res_step_pulse,
		res_status == STATUS_OK)

endmodule

bind plotter_line_step_generator plg_checker u_plg_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_ready       (cmd.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_status      (res.status),
	.res_step_pulse  (res.step_pulse),
	.res_motor_a_dir (res.motor_a_dir),
	.res_motor_b_dir (res.motor_b_dir)
);

// ===== tb/sv/plotter_line_step_generator_test.sv =====
// Self-checking test of the plotter line step generator: directed cases, then random
// move sequences under random idling and backpressure.
// Depends on plg_pkg and the channel interfaces in plg_ifs.sv.
module plotter_line_step_generator_test;
	import plg_pkg::*;

	localparam int COORD_W = 16;
	localparam int CNT_W   = 32;
	localparam int SETTLE  = COORD_W + 8;
	localparam int PHASE_ITEMS = 150;

	typedef struct {
		plg_status_t        status;
		logic               pulse;
		logic               dir_a;
		logic               dir_b;
		logic               pen;
		logic               busy;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [CNT_W-1:0]   cnt_a;
		logic [CNT_W-1:0]   cnt_b;
	} step_result_t;

	logic clk;
	logic arst_n;

	plg_cmd_if #(.COORD_WIDTH(COORD_W)) cmd_ch ();
	plg_res_if #(.COORD_WIDTH(COORD_W), .MOTOR_COUNT_WIDTH(CNT_W)) res_ch ();
	plg_cfg_if cfg_ch ();

	plotter_line_step_generator #(
		.COORD_WIDTH(COORD_W),
		.MOTOR_COUNT_WIDTH(CNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	// predicted block state
	logic [CFG_W-1:0] lim_x = '1;
	logic [CFG_W-1:0] lim_y = '1;
	longint walk_x = 0, walk_y = 0, walk_y0 = 0, walk_dx = 0, walk_dy = 0, walk_idx = 0;
	logic walk_busy = 1'b0;
	logic pen_down = 1'b0;
	logic [CNT_W-1:0] count_a = '0, count_b = '0;

	step_result_t step_results_due[$];

	// where the stimulus believes the pen head ends up
	longint plan_x = 0, plan_y = 0;

	int sent_count = 0;
	int result_count = 0;
	int mismatch_count = 0;
	int lines_started = 0, busy_rejects = 0, range_rejects = 0, motor_steps = 0;
	int cfg_writes = 0;
	int hold_left = 0;
	bit quiet_src = 1'b0;
	bit quiet_sink = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("plotter_line_step_generator_test: FAIL");
		$finish;
	end

	function automatic longint mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic longint y_goal();
		if (walk_dx == 0)
			return walk_y0 + walk_dy;
		return walk_y0 + (walk_dy * walk_idx) / mag(walk_dx);
	endfunction

	// one item through the line walker; returns the result it must produce
	function automatic step_result_t walk_line_step(input logic kind,
			input logic signed [COORD_W-1:0] tx, input logic signed [COORD_W-1:0] ty,
			input logic pen);
		step_result_t r;
		longint adx;
		longint goal;
		r.status = STATUS_OK;
		r.pulse = 1'b0;
		r.dir_a = 1'b0;
		r.dir_b = 1'b0;
		if (kind == REQ_MOVE) begin
			if (walk_busy) begin
				r.status = STATUS_BUSY;
			end else begin
				pen_down = pen;
				if (longint'(tx) > longint'(lim_x) || longint'(ty) > longint'(lim_y)) begin
					r.status = STATUS_RANGE;
				end else if (longint'(tx) != walk_x || longint'(ty) != walk_y) begin
					walk_y0 = walk_y;
					walk_dx = longint'(tx) - walk_x;
					walk_dy = longint'(ty) - walk_y;
					walk_idx = 0;
					walk_busy = 1'b1;
				end
			end
		end else if (walk_busy) begin
			adx = mag(walk_dx);
			goal = y_goal();
			if (walk_y != goal) begin
				r.pulse = 1'b1;
				if (goal > walk_y) begin
					r.dir_a = 1'b1;
					walk_y++;
				end else begin
					r.dir_b = 1'b1;
					walk_y--;
				end
			end else if (walk_idx < adx) begin
				r.pulse = 1'b1;
				walk_idx++;
				if (walk_dx > 0) begin
					r.dir_a = 1'b1;
					r.dir_b = 1'b1;
					walk_x++;
				end else begin
					walk_x--;
				end
			end
			if (r.pulse) begin
				count_a = r.dir_a ? count_a + 1'b1 : count_a - 1'b1;
				count_b = r.dir_b ? count_b + 1'b1 : count_b - 1'b1;
			end
			if (walk_idx >= adx && walk_y == y_goal())
				walk_busy = 1'b0;
		end
		r.pen = pen_down;
		r.busy = walk_busy;
		r.px = COORD_W'(walk_x);
		r.py = COORD_W'(walk_y);
		r.cnt_a = count_a;
		r.cnt_b = count_b;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [CNT_W-1:0] got,
			input logic [CNT_W-1:0] want);
		$display("%0t: result %0d %s mismatch: got %h, expected %h",
			$time, result_count, field, got, want);
		mismatch_count++;
	endtask

	task automatic check_result();
		step_result_t want;
		if (step_results_due.size() == 0) begin
			$display("%0t: result beat with nothing expected", $time);
			mismatch_count++;
			return;
		end
		want = step_results_due.pop_front();
		if (res_ch.status !== want.status)
			report_mismatch("status", CNT_W'(res_ch.status), CNT_W'(want.status));
		if (res_ch.step_pulse !== want.pulse)
			report_mismatch("step_pulse", CNT_W'(res_ch.step_pulse), CNT_W'(want.pulse));
		if (res_ch.motor_a_dir !== want.dir_a)
			report_mismatch("motor_a_dir", CNT_W'(res_ch.motor_a_dir), CNT_W'(want.dir_a));
		if (res_ch.motor_b_dir !== want.dir_b)
			report_mismatch("motor_b_dir", CNT_W'(res_ch.motor_b_dir), CNT_W'(want.dir_b));
		if (res_ch.pen_level !== want.pen)
			report_mismatch("pen_level", CNT_W'(res_ch.pen_level), CNT_W'(want.pen));
		if (res_ch.busy_res !== want.busy)
			report_mismatch("busy_res", CNT_W'(res_ch.busy_res), CNT_W'(want.busy));
		if (res_ch.pos_x !== want.px)
			report_mismatch("pos_x", CNT_W'(res_ch.pos_x), CNT_W'(want.px));
		if (res_ch.pos_y !== want.py)
			report_mismatch("pos_y", CNT_W'(res_ch.pos_y), CNT_W'(want.py));
		if (res_ch.motor_a_count !== want.cnt_a)
			report_mismatch("motor_a_count", res_ch.motor_a_count, want.cnt_a);
		if (res_ch.motor_b_count !== want.cnt_b)
			report_mismatch("motor_b_count", res_ch.motor_b_count, want.cnt_b);
	endtask

	// all beats are sampled at the edge, before this edge's drives land
	always @(posedge clk) begin
		step_result_t r;
		if (arst_n) begin
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				check_result();
				result_count++;
			end
			if (cmd_ch.valid && cmd_ch.ready === 1'b1) begin
				r = walk_line_step(cmd_ch.req_type, cmd_ch.target_x, cmd_ch.target_y,
					cmd_ch.pen_request);
				step_results_due.push_back(r);
				if (r.status == STATUS_BUSY)
					busy_rejects++;
				if (r.status == STATUS_RANGE)
					range_rejects++;
				if (cmd_ch.req_type == REQ_MOVE && r.status == STATUS_OK && r.busy)
					lines_started++;
				if (r.pulse)
					motor_steps++;
			end
			if (cfg_ch.valid && cfg_ch.ready === 1'b1) begin
				cfg_writes++;
				if (cfg_ch.index == CFG_MAX_X)
					lim_x = cfg_ch.value[CFG_W-1:0];
				else if (cfg_ch.index == CFG_MAX_Y)
					lim_y = cfg_ch.value[CFG_W-1:0];
			end
		end
	end

	// result sink: random stalls, plus a long hold-off on request
	initial begin
		int stall;
		stall = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				res_ch.ready <= 1'b0;
			end else begin
				stall = pick_gap(quiet_sink);
				res_ch.ready <= (stall == 0);
			end
		end
	end

	// valid stays high on return; the next send with a gap, or a drain, lowers it
	task automatic send_item(input logic kind, input logic [COORD_W-1:0] tx,
			input logic [COORD_W-1:0] ty, input logic pen);
		int gap;
		gap = pick_gap(quiet_src);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.req_type <= kind;
		cmd_ch.target_x <= tx;
		cmd_ch.target_y <= ty;
		cmd_ch.pen_request <= pen;
		cmd_ch.valid <= 1'b1;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		sent_count++;
	endtask

	task automatic send_tick();
		send_item(REQ_TICK, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
	endtask

	task automatic wait_drained(input int settle);
		cmd_ch.valid <= 1'b0;
		while (result_count < sent_count)
			@(posedge clk);
		repeat (settle + 1) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		cfg_ch.index <= idx;
		cfg_ch.value <= v;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// command plus every tick that the line needs; noise_pct adds commands while busy
	task automatic move_line(input longint tx, input longint ty, input logic pen,
			input int noise_pct);
		longint moves;
		bit in_range;
		in_range = tx <= longint'(lim_x) && ty <= longint'(lim_y);
		send_item(REQ_MOVE, COORD_W'(tx), COORD_W'(ty), pen);
		moves = 0;
		if (in_range) begin
			moves = mag(tx - plan_x) + mag(ty - plan_y);
			plan_x = tx;
			plan_y = ty;
		end
		for (longint k = 0; k < moves; k++) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_item(REQ_MOVE, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
			send_tick();
		end
	endtask

	function automatic longint rand_offset(input int near, input int far);
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 0;
		if (r < 90)
			return longint'($urandom_range(0, 2 * near)) - near;
		return longint'($urandom_range(0, 2 * far)) - far;
	endfunction

	function automatic longint pick_target(input longint from, input longint off,
			input logic [CFG_W-1:0] lim);
		longint t;
		t = from + off;
		if (t > 3000)
			t = 3000;
		if (t < -3000)
			t = -3000;
		// most targets beyond the limit are pulled back inside the allowed area
		if (t > longint'(lim) && $urandom_range(0, 99) < 85)
			t = longint'(lim) - $urandom_range(0, 6);
		return t;
	endfunction

	task automatic random_line();
		longint tx, ty;
		tx = pick_target(plan_x, rand_offset(12, 40), lim_x);
		ty = pick_target(plan_y, rand_offset(12, 60), lim_y);
		move_line(tx, ty, 1'($urandom), 4);
		if ($urandom_range(0, 99) < 20)
			repeat ($urandom_range(1, 2)) send_tick();
		if (lim_x != '1 && $urandom_range(0, 99) < 8)
			send_item(REQ_MOVE, COORD_W'($urandom_range(int'(lim_x) + 1, 32767)),
				COORD_W'($urandom), 1'($urandom));
	endtask

	task automatic test_idle_requests();
		send_tick();
		move_line(plan_x, plan_y, 1'b1, 0);
		send_tick();
	endtask

	task automatic test_line_directions();
		// right and down, with a command that arrives mid-line and must be dropped whole
		send_item(REQ_MOVE, COORD_W'(3), COORD_W'(-5), 1'b1);
		send_item(REQ_MOVE, 16'h8000, 16'h7fff, 1'b0);
		repeat (8) send_tick();
		plan_x = 3;
		plan_y = -5;
		move_line(-1, 0, 1'b0, 0);
	endtask

	task automatic test_range_limits();
		wait_drained(SETTLE);
		write_reg(CFG_MAX_X, 16'h8000);
		write_reg(CFG_MAX_Y, 16'h0000);
		send_item(REQ_MOVE, COORD_W'(1), 16'h8000, 1'b1);
		send_item(REQ_MOVE, 16'h8000, COORD_W'(1), 1'b0);
		send_item(REQ_MOVE, 16'h7fff, 16'h7fff, 1'b1);
		// pure vertical line
		move_line(plan_x, plan_y - 3, 1'b0, 0);
		wait_drained(SETTLE);
		write_reg(CFG_MAX_Y + 1'b1, 16'hffff);
		write_reg(CFG_IDX_W'($urandom_range(CFG_MAX_Y + 2, 255)), 16'h7fff);
		send_item(REQ_MOVE, COORD_W'(plan_x), COORD_W'(1), 1'b1);
	endtask

	task automatic test_result_backpressure();
		wait_drained(SETTLE);
		write_reg(CFG_MAX_X, 16'hffff);
		write_reg(CFG_MAX_Y, 16'h7fff);
		quiet_src = 1'b1;
		hold_left = 150;
		move_line(plan_x + 4, plan_y - 9, 1'b1, 0);
		quiet_src = 1'b0;
	endtask

	task automatic test_pause_mid_line();
		send_item(REQ_MOVE, COORD_W'(plan_x - 3), COORD_W'(plan_y + 4), 1'b0);
		repeat (3) send_tick();
		wait_drained(0);
		repeat (4) send_tick();
		plan_x -= 3;
		plan_y += 4;
	endtask

	task automatic test_random_phases();
		int start;
		for (int phase = 0; phase < 6; phase++) begin
			wait_drained(SETTLE);
			case (phase)
				0: begin
					write_reg(CFG_MAX_X, 16'h7fff);
					write_reg(CFG_MAX_Y, 16'hffff);
				end
				1: begin
					write_reg(CFG_MAX_X, 16'h8000);
					write_reg(CFG_MAX_Y, 16'h0000);
				end
				2: begin
					write_reg(CFG_MAX_X, CFG_DATA_W'($urandom_range(0, 40)));
					write_reg(CFG_MAX_Y, CFG_DATA_W'($urandom));
				end
				3: begin
					write_reg(CFG_MAX_X, 16'hffff);
					write_reg(CFG_MAX_Y, CFG_DATA_W'($urandom_range(0, 30)));
				end
				4: begin
					write_reg(CFG_MAX_X, CFG_DATA_W'($urandom));
					write_reg(CFG_MAX_Y, CFG_DATA_W'($urandom));
					write_reg(CFG_IDX_W'($urandom_range(CFG_MAX_Y + 1, 255)),
						CFG_DATA_W'($urandom));
				end
				default: begin
					write_reg(CFG_MAX_X, 16'h7fff);
					write_reg(CFG_MAX_Y, 16'h7fff);
				end
			endcase
			// one phase runs with no idling on either side
			quiet_src = (phase == 3);
			quiet_sink = (phase == 3);
			start = sent_count;
			while (sent_count - start < PHASE_ITEMS)
				random_line();
		end
		quiet_src = 1'b0;
		quiet_sink = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.req_type <= REQ_TICK;
		cmd_ch.target_x <= '0;
		cmd_ch.target_y <= '0;
		cmd_ch.pen_request <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_MAX_X;
		cfg_ch.value <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_requests();
		test_line_directions();
		test_range_limits();
		test_result_backpressure();
		test_pause_mid_line();
		test_random_phases();

		wait_drained(SETTLE);
		if (step_results_due.size() != 0) begin
			$display("%0d expected results never arrived", step_results_due.size());
			mismatch_count++;
		end
		$display("run covered %0d items, %0d lines, %0d motor steps, %0d config writes",
			sent_count, lines_started, motor_steps, cfg_writes);
		$display("rejected %0d commands while busy and %0d out of range; %0d mismatches",
			busy_rejects, range_rejects, mismatch_count);
		if (mismatch_count == 0)
			$display("plotter_line_step_generator_test: PASS");
		else
			$display("plotter_line_step_generator_test: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/plg_pkg.sv
rtl/plg_ifs.sv
rtl/plotter_line_step_generator.sv
rtl/plg_checker.sv
tb/sv/plotter_line_step_generator_test.sv
